// ===== src/sdcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcf_pkg
// Shared types and constants of the serial display command framer.
// ----------------------------------------------------------------------------
package sdcf_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH       = 2;
  localparam int BYTE_W            = 8;
  localparam int DATA_INDEX_W      = 6;
  localparam int COUNT_W           = 7;
  localparam int CFG_INDEX_W       = 3;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BITMAP     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOUR     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ON         = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_DROP_NL    = 3'd7;

  typedef enum logic [2:0] {
    CMD_BITMAP = 3'd0,
    CMD_COLOUR = 3'd1,
    CMD_BRIGHT = 3'd2,
    CMD_OFF    = 3'd3,
    CMD_ON     = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    FR_IDLE   = 3'd0,
    FR_READY  = 3'd1,
    FR_BITMAP = 3'd2,
    FR_COLOUR = 3'd3,
    FR_BRIGHT = 3'd4
  } fr_state_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] bitmap_byte;
    logic [BYTE_W-1:0] colour_byte;
    logic [BYTE_W-1:0] brightness_byte;
    logic [BYTE_W-1:0] off_byte;
    logic [BYTE_W-1:0] on_byte;
    logic              drop_newline;
  } cfg_t;

  // one framed command waiting for the back end
  typedef struct packed {
    cmd_t               cmd;
    logic [BYTE_W-1:0]  first_arg;
    logic [COUNT_W-1:0] count;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/sdcf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcf_in_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface sdcf_in_if;
  logic                          valid;
  logic                          ready;
  logic [sdcf_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/sdcf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcf_out_if
// Display command channel: valid/ready handshake with one command request.
// ----------------------------------------------------------------------------
interface sdcf_out_if;
  logic                             valid;
  logic                             ready;
  sdcf_pkg::cmd_t                   command;
  logic [sdcf_pkg::BYTE_W-1:0]      first_arg;
  logic [sdcf_pkg::BYTE_W-1:0]      second_arg;
  logic [sdcf_pkg::DATA_INDEX_W-1:0] data_index;
  logic [sdcf_pkg::COUNT_W-1:0]     payload_count;
  logic                             last;

  modport source (output valid, output command, output first_arg, output second_arg,
                  output data_index, output payload_count, output last, input ready);
  modport sink   (input valid, input command, input first_arg, input second_arg,
                  input data_index, input payload_count, input last, output ready);
endinterface

// ===== src/sdcf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/sdcf_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcf_cmd_fifo
// Short queue of framed command descriptors between front and back end.
// ----------------------------------------------------------------------------
module sdcf_cmd_fifo #(
  parameter int DEPTH = sdcf_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sdcf_pkg::desc_t     push_data,
  input  logic                pop,
  output sdcf_pkg::desc_t     pop_data,
  output sdcf_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sdcf_pkg::desc_t  entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = entry_r[rd_ptr_r];
  assign status.full  = (cnt_r == CNT_W'(DEPTH));
  assign status.empty = (cnt_r == '0);

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("command queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("command queue underflow");

endmodule

// ===== src/sdcf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcf_front
// Byte classifier: frames commands, fills the payload store, queues commands.
// ----------------------------------------------------------------------------
module sdcf_front #(
  parameter int PAYLOAD_DEPTH = sdcf_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sdcf_pkg::cfg_t               cfg,
  sdcf_in_if.sink                      in_chan,
  input  sdcf_pkg::q_status_t          q_status,
  output logic                         push,
  output sdcf_pkg::desc_t              push_data,
  input  logic                         store_done,
  output logic                         wr_en,
  output logic [$clog2(PAYLOAD_DEPTH)-1:0] wr_addr,
  output logic [sdcf_pkg::BYTE_W-1:0]  wr_data
);

  localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
  localparam int FILL_W = $clog2(PAYLOAD_DEPTH + 1);
  localparam int BUSY_W = $clog2(sdcf_pkg::QUEUE_DEPTH + 2);

  sdcf_pkg::fr_state_t         state_r, state_nxt;
  logic [FILL_W-1:0]           fill_r, fill_nxt;
  logic [sdcf_pkg::BYTE_W-1:0] byte0_r, byte0_nxt;
  logic [BUSY_W-1:0]           busy_r, busy_nxt;

  logic                        accept;
  logic                        live;
  logic                        in_payload;
  logic                        is_close;
  logic                        is_fill;
  logic                        push_store;
  logic [sdcf_pkg::BYTE_W-1:0] c;

  assign c          = in_chan.rx_byte;
  assign in_payload = (state_r == sdcf_pkg::FR_BITMAP) || (state_r == sdcf_pkg::FR_COLOUR) ||
                      (state_r == sdcf_pkg::FR_BRIGHT);
  // hold input while the queue is full or, inside a payload, while the store is still being read
  assign in_chan.ready = !q_status.full && !(in_payload && (busy_r != '0));
  assign accept     = in_chan.valid && in_chan.ready;
  assign live       = accept && !(cfg.drop_newline && (c == sdcf_pkg::NEWLINE_BYTE));
  assign is_close   = (c == cfg.end_byte) || (c == cfg.start_byte);
  assign is_fill    = (fill_r == FILL_W'(PAYLOAD_DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    if (live) begin
      case (state_r)
        sdcf_pkg::FR_IDLE: begin
          if (c == cfg.start_byte) state_nxt = sdcf_pkg::FR_READY;
        end
        sdcf_pkg::FR_READY: begin
          if (c == cfg.bitmap_byte)          state_nxt = sdcf_pkg::FR_BITMAP;
          else if (c == cfg.colour_byte)     state_nxt = sdcf_pkg::FR_COLOUR;
          else if (c == cfg.brightness_byte) state_nxt = sdcf_pkg::FR_BRIGHT;
          else if ((c == cfg.off_byte) || (c == cfg.on_byte) || is_close)
            state_nxt = sdcf_pkg::FR_IDLE;
        end
        sdcf_pkg::FR_BITMAP, sdcf_pkg::FR_COLOUR, sdcf_pkg::FR_BRIGHT: begin
          if (is_close || is_fill) state_nxt = sdcf_pkg::FR_IDLE;
        end
        default: begin
          state_nxt = (c == cfg.start_byte) ? sdcf_pkg::FR_READY : sdcf_pkg::FR_IDLE;
        end
      endcase
    end
  end

  // outputs and datapath
  always_comb begin
    push                = 1'b0;
    push_data.cmd       = sdcf_pkg::CMD_OFF;
    push_data.first_arg = '0;
    push_data.count     = '0;
    wr_en               = 1'b0;
    wr_addr             = fill_r[ADDR_W-1:0];
    wr_data             = c;
    fill_nxt            = fill_r;
    byte0_nxt           = byte0_r;
    if (live) begin
      case (state_r)
        sdcf_pkg::FR_READY: begin
          if ((c != cfg.bitmap_byte) && (c != cfg.colour_byte) &&
              (c != cfg.brightness_byte)) begin
            if (c == cfg.off_byte) begin
              push          = 1'b1;
              push_data.cmd = sdcf_pkg::CMD_OFF;
            end else if (c == cfg.on_byte) begin
              push          = 1'b1;
              push_data.cmd = sdcf_pkg::CMD_ON;
            end
          end
        end
        sdcf_pkg::FR_BITMAP, sdcf_pkg::FR_COLOUR, sdcf_pkg::FR_BRIGHT: begin
          case (state_r)
            sdcf_pkg::FR_BITMAP: push_data.cmd = sdcf_pkg::CMD_BITMAP;
            sdcf_pkg::FR_COLOUR: push_data.cmd = sdcf_pkg::CMD_COLOUR;
            default:             push_data.cmd = sdcf_pkg::CMD_BRIGHT;
          endcase
          push_data.first_arg = (fill_r != '0) ? byte0_r : '0;
          if (is_close) begin
            push            = 1'b1;
            push_data.count = sdcf_pkg::COUNT_W'(fill_r);
            fill_nxt        = '0;
          end else begin
            wr_en = 1'b1;
            if (fill_r == '0) byte0_nxt = c;
            if (is_fill) begin
              push            = 1'b1;
              push_data.count = sdcf_pkg::COUNT_W'(PAYLOAD_DEPTH);
              fill_nxt        = '0;
            end else begin
              fill_nxt = fill_r + 1'b1;
            end
          end
        end
        default: begin
          fill_nxt = '0;
        end
      endcase
    end
  end

  assign push_store = push && ((push_data.cmd == sdcf_pkg::CMD_BITMAP) ||
                               (push_data.cmd == sdcf_pkg::CMD_COLOUR));
  assign busy_nxt   = busy_r + BUSY_W'(push_store) - BUSY_W'(store_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdcf_pkg::FR_IDLE;
      fill_r  <= '0;
      busy_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte0_r <= byte0_nxt;
  end

  a_no_write_while_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (busy_r == '0))
    else $error("payload store written while back end still reads it");

  a_busy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r <= BUSY_W'(sdcf_pkg::QUEUE_DEPTH + 1))
    else $error("store user count out of range");

endmodule

// ===== src/sdcf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcf_back
// Command executor: walks the payload store and drives the output register.
// ----------------------------------------------------------------------------
module sdcf_back #(
  parameter int PAYLOAD_DEPTH = sdcf_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sdcf_pkg::q_status_t          q_status,
  input  sdcf_pkg::desc_t              q_data,
  output logic                         pop,
  output logic                         rd_en,
  output logic [$clog2(PAYLOAD_DEPTH)-1:0] rd_addr,
  input  logic [sdcf_pkg::BYTE_W-1:0]  rd_data,
  output logic                         store_done,
  sdcf_out_if.source                   out_chan
);

  localparam int IDX_W = $clog2(PAYLOAD_DEPTH);

  sdcf_pkg::bk_state_t state_r, state_nxt;
  sdcf_pkg::desc_t     desc_r, desc_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  logic                              out_valid_r, out_valid_nxt;
  sdcf_pkg::cmd_t                    out_cmd_r;
  logic [sdcf_pkg::BYTE_W-1:0]       out_first_r, out_second_r;
  logic [sdcf_pkg::DATA_INDEX_W-1:0] out_index_r;
  logic [sdcf_pkg::COUNT_W-1:0]      out_count_r;
  logic                              out_last_r;

  logic                        slot_free;
  logic                        load;
  logic                        uses_store;
  logic                        more;
  logic [sdcf_pkg::BYTE_W-1:0] stored;

  assign slot_free  = !out_valid_r || out_chan.ready;
  assign uses_store = (desc_r.cmd == sdcf_pkg::CMD_BITMAP) ||
                      (desc_r.cmd == sdcf_pkg::CMD_COLOUR);
  assign more       = (desc_r.cmd == sdcf_pkg::CMD_BITMAP) &&
                      (idx_r != IDX_W'(PAYLOAD_DEPTH - 1));
  // entries at or past the fill count are masked and read as zero
  assign stored     = (sdcf_pkg::COUNT_W'(idx_r) < desc_r.count) ? rd_data : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdcf_pkg::BK_IDLE: begin
        if (!q_status.empty) state_nxt = sdcf_pkg::BK_EMIT;
      end
      sdcf_pkg::BK_EMIT: begin
        if (slot_free && !more) state_nxt = sdcf_pkg::BK_IDLE;
      end
      default: state_nxt = sdcf_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop        = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = IDX_W'(1);
    load       = 1'b0;
    store_done = 1'b0;
    desc_nxt   = desc_r;
    idx_nxt    = idx_r;
    case (state_r)
      sdcf_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop      = 1'b1;
          desc_nxt = q_data;
          idx_nxt  = IDX_W'(1);
          rd_en    = 1'b1;
        end
      end
      sdcf_pkg::BK_EMIT: begin
        if (slot_free) begin
          load = 1'b1;
          if (more) begin
            idx_nxt = idx_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_r + 1'b1;
          end else begin
            store_done = uses_store;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdcf_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    idx_r  <= idx_nxt;
    if (load) begin
      out_cmd_r    <= desc_r.cmd;
      out_first_r  <= desc_r.first_arg;
      out_second_r <= uses_store ? stored : '0;
      out_index_r  <= (desc_r.cmd == sdcf_pkg::CMD_BITMAP) ?
                      sdcf_pkg::DATA_INDEX_W'(idx_r) : '0;
      out_count_r  <= desc_r.count;
      out_last_r   <= !more;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.command       = out_cmd_r;
  assign out_chan.first_arg     = out_first_r;
  assign out_chan.second_arg    = out_second_r;
  assign out_chan.data_index    = out_index_r;
  assign out_chan.payload_count = out_count_r;
  assign out_chan.last          = out_last_r;

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    store_done |=> (state_r == sdcf_pkg::BK_IDLE))
    else $error("store released while a run is still open");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == sdcf_pkg::BK_IDLE))
    else $error("descriptor taken during a run");

endmodule

// ===== src/serial_display_command_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_display_command_framer
// Frames received serial bytes into display command requests.
// ----------------------------------------------------------------------------
// Each byte is taken when in_ready is high. The front end classifies it,
// fills the payload store and, on a payload close or an immediate off/on
// command, queues a command descriptor. The back end turns each descriptor
// into output requests: off, on and brightness give one request, colour one
// request after a store read, and bitmap PAYLOAD_DEPTH-1 requests at one per
// cycle, paced by the single read port of the payload store and by out_ready.
// A queued bitmap or colour command keeps the store until its last request is
// loaded; earlier commands in the queue and output stalls delay that release.
// During that time bytes that arrive inside the next payload are held off
// (in_ready low); bytes outside a payload keep flowing until the two-entry
// command queue fills. Store entries past the fill count read as zero, so no
// clearing pass runs after reset or at the end of a frame.
// ----------------------------------------------------------------------------
module serial_display_command_framer #(
  parameter int PAYLOAD_DEPTH = sdcf_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sdcf_in_if.sink                          in_chan,
  sdcf_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [sdcf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdcf_pkg::BYTE_W-1:0]      cfg_data
);

  localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

  sdcf_pkg::cfg_t      cfg_r, cfg_nxt;
  sdcf_pkg::q_status_t q_status;
  sdcf_pkg::desc_t     push_data, pop_data;
  logic                push, pop;
  logic                store_done;
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [sdcf_pkg::BYTE_W-1:0] wr_data, rd_data;

  // register file: update the addressed field, hold the rest
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sdcf_pkg::REG_START:      cfg_nxt.start_byte      = cfg_data;
        sdcf_pkg::REG_END:        cfg_nxt.end_byte        = cfg_data;
        sdcf_pkg::REG_BITMAP:     cfg_nxt.bitmap_byte     = cfg_data;
        sdcf_pkg::REG_COLOUR:     cfg_nxt.colour_byte     = cfg_data;
        sdcf_pkg::REG_BRIGHTNESS: cfg_nxt.brightness_byte = cfg_data;
        sdcf_pkg::REG_OFF:        cfg_nxt.off_byte        = cfg_data;
        sdcf_pkg::REG_ON:         cfg_nxt.on_byte         = cfg_data;
        sdcf_pkg::REG_DROP_NL:    cfg_nxt.drop_newline    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte      <= 8'd2;
      cfg_r.end_byte        <= 8'd3;
      cfg_r.bitmap_byte     <= 8'd66;
      cfg_r.colour_byte     <= 8'd67;
      cfg_r.brightness_byte <= 8'd76;
      cfg_r.off_byte        <= 8'd70;
      cfg_r.on_byte         <= 8'd78;
      cfg_r.drop_newline    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify bytes, fill the store, queue commands
  sdcf_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_chan    (in_chan),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data),
    .store_done (store_done),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // decouple framing from request delivery
  sdcf_cmd_fifo #(.DEPTH(sdcf_pkg::QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // payload store
  sdcf_ram #(.WIDTH(sdcf_pkg::BYTE_W), .DEPTH(PAYLOAD_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // walk the store and emit requests
  sdcf_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_data     (pop_data),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .store_done (store_done),
    .out_chan   (out_chan)
  );

endmodule
